[src/ttrc_pkg.sv]
// ttrc_pkg: shared types, constants and modulo helpers for the
// three-term recurrence checksum. No dependencies.
package ttrc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned POS_W  = 8;
   localparam int unsigned TERM_W = 16;
   localparam int unsigned PROD_W = 25;

   localparam logic [TERM_W-1:0] MODULUS      = 16'hFFFF;
   localparam logic [POS_W-1:0]  ALPHA_STEP   = 8'd17;
   localparam logic [POS_W-1:0]  BETA_STEP    = 8'd31;
   localparam logic [TERM_W-1:0] FIRST_OFFSET = 16'd7;
   localparam logic [TERM_W-1:0] OLDER_RESET  = 16'd1;
   localparam logic [POS_W-1:0]  POS_FIRST    = 8'd1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } beat_type;

   // end-around fold: 2^16 is 1 modulo 65535
   function automatic logic [TERM_W-1:0] mod_modulus(input logic [PROD_W-1:0] x);
      logic [TERM_W:0] s1;
      logic [TERM_W:0] s2;
      s1 = 17'(x[PROD_W-1:TERM_W]) + 17'(x[TERM_W-1:0]);
      s2 = 17'(s1[TERM_W]) + 17'(s1[TERM_W-1:0]);
      if (s2 >= 17'(MODULUS)) begin
         return 16'(s2 - 17'(MODULUS));
      end
      return 16'(s2);
   endfunction

   // (1 - r) mod 65535 for a reduced magnitude r
   function automatic logic [TERM_W-1:0] wrap_negative(input logic [TERM_W-1:0] r);
      if (r <= OLDER_RESET) begin
         return 16'(OLDER_RESET - r);
      end
      return 16'(17'h10000 - 17'(r));
   endfunction

endpackage

[src/ttrc_in_stage.sv]
// ttrc_in_stage: input register for one byte beat.
// Depends on ttrc_pkg for beat_type.
module ttrc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ttrc_pkg::beat_type req_beat,
   input  logic              advance,
   output logic              beat_valid,
   output ttrc_pkg::beat_type beat
);
   import ttrc_pkg::*;

   logic     valid_ff, valid_in;
   beat_type beat_ff;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff <= req_beat;
      end
   end

   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

endmodule

[src/ttrc_term.sv]
// ttrc_term: next recurrence term from one byte and the two held terms.
// Depends on ttrc_pkg for widths, coefficients and modulo helpers.
module ttrc_term (
   input  logic [ttrc_pkg::BYTE_W-1:0] data_byte,
   input  logic [ttrc_pkg::POS_W-1:0]  position,
   input  logic [ttrc_pkg::TERM_W-1:0] older,
   input  logic [ttrc_pkg::TERM_W-1:0] newer,
   output logic [ttrc_pkg::TERM_W-1:0] term
);
   import ttrc_pkg::*;

   logic [POS_W-1:0]  alpha, beta;
   logic [POS_W:0]    factor;
   logic [PROD_W-1:0] plus, minus, mag;
   logic [TERM_W-1:0] rem;
   logic              negative;

   always_comb begin
      alpha    = 8'(position * ALPHA_STEP);
      beta     = 8'(position * BETA_STEP);
      factor   = 9'(data_byte) + 9'(alpha);
      plus     = 25'(factor) * 25'(newer);
      minus    = 25'(beta) * 25'(older);
      negative = plus < minus;
      mag      = negative ? (minus - plus) : (plus - minus);
      rem      = mod_modulus(mag);
      term     = negative ? wrap_negative(rem) : rem;
   end

endmodule

[src/ttrc_accum.sv]
// ttrc_accum: recurrence state registers and the result register.
// Depends on ttrc_pkg; takes the next term from ttrc_term.
module ttrc_accum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        beat_valid,
   input  ttrc_pkg::beat_type          beat,
   input  logic [ttrc_pkg::TERM_W-1:0] term,
   output logic [ttrc_pkg::POS_W-1:0]  position,
   output logic [ttrc_pkg::TERM_W-1:0] older,
   output logic [ttrc_pkg::TERM_W-1:0] newer,
   output logic                        advance,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ttrc_pkg::TERM_W-1:0] rsp_checksum
);
   import ttrc_pkg::*;

   logic [TERM_W-1:0] older_ff, older_in, newer_ff, newer_in;
   logic [TERM_W-1:0] checksum_ff, step_newer;
   logic [POS_W-1:0]  position_ff, position_in;
   logic              in_message_ff, in_message_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // a last beat waits while the result register is still full
   assign advance = beat_valid && (!beat.last_byte || !rsp_valid_ff || rsp_ready);

   always_comb begin
      older_in      = older_ff;
      newer_in      = newer_ff;
      position_in   = position_ff;
      in_message_in = in_message_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      step_newer    = in_message_ff ? term : 16'(beat.data_byte) + FIRST_OFFSET;
      if (advance) begin
         if (beat.last_byte) begin
            older_in      = OLDER_RESET;
            newer_in      = '0;
            position_in   = '0;
            in_message_in = 1'b0;
            rsp_valid_in  = 1'b1;
         end else if (in_message_ff) begin
            older_in    = newer_ff;
            newer_in    = term;
            position_in = position_ff + 8'd1;
         end else begin
            older_in      = OLDER_RESET;
            newer_in      = step_newer;
            position_in   = POS_FIRST;
            in_message_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         older_ff      <= OLDER_RESET;
         newer_ff      <= '0;
         position_ff   <= '0;
         in_message_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         older_ff      <= older_in;
         newer_ff      <= newer_in;
         position_ff   <= position_in;
         in_message_ff <= in_message_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && beat.last_byte) begin
         checksum_ff <= step_newer;
      end
   end

   assign position     = position_ff;
   assign older        = older_ff;
   assign newer        = newer_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_checksum = checksum_ff;

endmodule

[src/three_term_recurrence_checksum.sv]
// three_term_recurrence_checksum: top level of the byte stream checksum.
// Depends on ttrc_pkg, ttrc_in_stage, ttrc_term and ttrc_accum.
//
// Bytes of a message arrive as beats on the req_ channel (valid/ready),
// with req_last_byte marking the final byte. After the last byte one beat
// leaves on the rsp_ channel carrying the 16-bit checksum; other bytes
// give no output. Each beat is first held in an input register, then the
// next term is formed combinationally (one 9x16 and one 8x16 multiply,
// a subtract and an end-around modulo 65535 fold) and the state registers
// take it. Throughput is one byte per cycle unless a last byte stalls as
// below. rsp_valid is registered: a last byte passes the input register
// and sets rsp_valid when the state registers take it. While a checksum
// waits in the result register, non-last bytes keep flowing; a further
// last byte waits in the input register, and the input stalls only then.
// Synchronous reset empties both registers and starts a fresh message.
module three_term_recurrence_checksum (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ttrc_pkg::BYTE_W-1:0] req_data_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ttrc_pkg::TERM_W-1:0] rsp_checksum
);
   import ttrc_pkg::*;

   beat_type          req_beat, beat;
   logic              beat_valid, advance;
   logic [POS_W-1:0]  position;
   logic [TERM_W-1:0] older, newer, term;

   assign req_beat.data_byte = req_data_byte;
   assign req_beat.last_byte = req_last_byte;

   ttrc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_beat   (req_beat),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   ttrc_term u_term (
      .data_byte (beat.data_byte),
      .position  (position),
      .older     (older),
      .newer     (newer),
      .term      (term)
   );

   ttrc_accum u_accum (
      .clock        (clock),
      .reset        (reset),
      .beat_valid   (beat_valid),
      .beat         (beat),
      .term         (term),
      .position     (position),
      .older        (older),
      .newer        (newer),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_checksum (rsp_checksum)
   );

endmodule
